### rtl/core/polygon_depth_plane_clipper_assert.svh
// Assertion macros for the depth-plane clipper
`ifndef POLYGON_DEPTH_PLANE_CLIPPER_ASSERT_SVH
`define POLYGON_DEPTH_PLANE_CLIPPER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define PDPC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define PDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/core/pdpc_pkg.sv
// Package: types and constants of the depth-plane clipper
`timescale 1ns / 1ps
package pdpc_pkg;
   localparam int CoordBits = 32;
   localparam int FracBits  = 16;
   localparam int NumComp   = 7;
   localparam int CompBits  = 3;
   localparam int CsrIdxBits = 1;
   localparam int CsrDataBits = CoordBits;
   localparam int WBits     = CoordBits + 2;
   localparam int TBits     = FracBits + 1;
   localparam int CntBits   = 5;

   localparam logic [CsrIdxBits-1:0] CSR_PLANE = 1'd0;
   localparam logic [CsrIdxBits-1:0] CSR_KEEP  = 1'd1;

   typedef struct packed {
      logic signed [CoordBits-1:0] pos_x;
      logic signed [CoordBits-1:0] pos_y;
      logic signed [CoordBits-1:0] pos_z;
      logic signed [CoordBits-1:0] pos_w;
      logic signed [CoordBits-1:0] bary_a;
      logic signed [CoordBits-1:0] bary_b;
      logic signed [CoordBits-1:0] bary_c;
      logic                        final_vertex;
   } req_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] out_x;
      logic signed [CoordBits-1:0] out_y;
      logic signed [CoordBits-1:0] out_z;
      logic signed [CoordBits-1:0] out_w;
      logic signed [CoordBits-1:0] out_bary_a;
      logic signed [CoordBits-1:0] out_bary_b;
      logic signed [CoordBits-1:0] out_bary_c;
      logic                        vertex_valid;
      logic                        polygon_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EDGE, ST_DIV, ST_BLEND, ST_EMIT_X, ST_EMIT_B, ST_NEXT, ST_MARK
   } state_type;
endpackage

### rtl/core/polygon_depth_plane_clipper.sv
// Top level: streamed single-plane polygon clipper
`timescale 1ns / 1ps
// Depth-plane polygon clipper.
// req_ takes one vertex word per handshake; final_vertex closes the polygon.
// rsp_ gives the clipped vertices, in edge order; the last word of a polygon
// carries polygon_end (a bare end marker if the final vertex emits nothing).
// csr_ writes plane_position (index 0) and keep_greater (index 1); the user
// must write them only while idle, which the block itself does not enforce.
// Each edge that crosses runs a restoring divider for t: a first compare, then
// one quotient bit a cycle, then seven multiply-blends on a shared 33x17
// multiplier, one component a cycle. The final vertex of a polygon of two or
// more vertices handles its open edge and then the closing edge. The block
// takes no new vertex until all words of the current one are delivered.
// A stalled receiver simply holds the block in its emit step; nothing is lost.
// Reset restores plane 1.0, near mode and the polygon-start flag.
module polygon_depth_plane_clipper
   import pdpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_wdata
);
`include "polygon_depth_plane_clipper_assert.svh"

   typedef logic signed [CoordBits-1:0] comp_type [NumComp];

   state_type state_ff, state_in;
   logic signed [CoordBits-1:0] plane_ff;
   logic keep_ff;
   comp_type first_ff, prev_ff, cur_ff, cross_ff;
   logic start_ff, start_in;
   logic fin_ff, fin_in;
   logic close_ff, close_in;       // working on closing edge
   logic emitted_ff, emitted_in;   // any vertex emitted this vertex word
   logic [WBits-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [TBits-1:0] t_ff, t_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [CompBits-1:0] comp_ff, comp_in;
   logic load_cur, save_cross;

   // edge ends
   comp_type ea, eb;
   always_comb begin
      for (int j = 0; j < NumComp; j++) begin
         ea[j] = close_ff ? cur_ff[j] : prev_ff[j];
         eb[j] = close_ff ? first_ff[j] : cur_ff[j];
      end
   end

   logic in_a, out_a, in_b, out_b;
   always_comb begin
      in_a  = keep_ff ? (ea[3] > plane_ff) : (ea[3] < plane_ff);
      out_a = keep_ff ? (ea[3] < plane_ff) : (ea[3] > plane_ff);
      in_b  = keep_ff ? (eb[3] > plane_ff) : (eb[3] < plane_ff);
      out_b = keep_ff ? (eb[3] < plane_ff) : (eb[3] > plane_ff);
   end

   // the closing edge is empty when both its ends lie outside
   logic out_cur, out_first, close_empty;
   always_comb begin
      out_cur = keep_ff ? (cur_ff[3] < plane_ff) : (cur_ff[3] > plane_ff);
      out_first = keep_ff ? (first_ff[3] < plane_ff) : (first_ff[3] > plane_ff);
      close_empty = out_cur && out_first;
   end

   logic signed [CoordBits:0] da, db;
   logic [WBits-1:0] wa, wb;
   assign da = $signed({ea[3][CoordBits-1], ea[3]})
               - $signed({plane_ff[CoordBits-1], plane_ff});
   assign db = $signed({eb[3][CoordBits-1], eb[3]})
               - $signed({plane_ff[CoordBits-1], plane_ff});
   assign wa = WBits'(da[CoordBits] ? -da : da);
   assign wb = WBits'(db[CoordBits] ? -db : db);

   // divider step
   logic [WBits-1:0] rem_sh;
   logic rem_ge;
   assign rem_sh = {rem_ff[WBits-2:0], 1'b0};
   assign rem_ge = rem_sh >= den_ff;

   // shared blend unit
   logic signed [CoordBits:0] dd;
   logic [CoordBits:0] mag;
   logic [CoordBits+TBits:0] prod;
   logic [CoordBits:0] pinc;
   logic signed [CoordBits-1:0] blended;
   assign dd = $signed({eb[comp_ff][CoordBits-1], eb[comp_ff]})
               - $signed({ea[comp_ff][CoordBits-1], ea[comp_ff]});
   assign mag = dd[CoordBits] ? (CoordBits+1)'(-dd) : (CoordBits+1)'(dd);
   assign prod = mag * t_ff + ((CoordBits+TBits+1)'(1) << (FracBits-1));
   assign pinc = prod[FracBits +: CoordBits+1];
   assign blended = dd[CoordBits] ? CoordBits'(ea[comp_ff] - pinc[CoordBits-1:0])
                                  : CoordBits'(ea[comp_ff] + pinc[CoordBits-1:0]);

   rsp_type rsp_in;

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      fin_in = fin_ff;
      close_in = close_ff;
      emitted_in = emitted_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      t_in = t_ff;
      cnt_in = cnt_ff;
      comp_in = comp_ff;
      load_cur = 1'b0;
      save_cross = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               load_cur = 1'b1;
               fin_in = req_data.final_vertex;
               emitted_in = 1'b0;
               close_in = start_ff;
               start_in = 1'b0;
               state_in = start_ff ? (req_data.final_vertex ? ST_EDGE : ST_NEXT)
                                   : ST_EDGE;
            end
         end
         ST_EDGE: begin
            if (out_a && out_b) state_in = ST_NEXT;
            else if (in_a && in_b) state_in = ST_EMIT_B;
            else begin
               den_in = wa + wb;
               if (wa + wb == '0) begin
                  t_in = '0;
                  comp_in = '0;
                  state_in = ST_BLEND;
               end else begin
                  t_in = TBits'(wa >= wa + wb);
                  rem_in = (wa >= wa + wb) ? wa - (wa + wb) : wa;
                  cnt_in = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_sh - den_ff : rem_sh;
            t_in = {t_ff[TBits-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            comp_in = '0;
            if (cnt_ff == CntBits'(FracBits - 1)) state_in = ST_BLEND;
         end
         ST_BLEND: begin
            save_cross = 1'b1;
            comp_in = comp_ff + 1'b1;
            if (comp_ff == CompBits'(NumComp - 1)) state_in = ST_EMIT_X;
         end
         ST_EMIT_X: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               emitted_in = 1'b1;
               state_in = (in_a && out_b) ? ST_NEXT : ST_EMIT_B;
            end
         end
         ST_EMIT_B: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               emitted_in = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (fin_ff && !close_ff) close_in = 1'b1;
            if (fin_ff && !close_ff) state_in = ST_EDGE;
            else if (fin_ff) state_in = ST_MARK;
            else begin
               close_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            // end marker only if nothing was emitted; else already flagged
            if (emitted_ff) begin
               start_in = 1'b1;
               close_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               rsp_valid = 1'b1;
               if (rsp_ready) begin
                  start_in = 1'b1;
                  close_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_EMIT_X) begin
         rsp_in.out_x = cross_ff[0]; rsp_in.out_y = cross_ff[1];
         rsp_in.out_z = cross_ff[2]; rsp_in.out_w = cross_ff[3];
         rsp_in.out_bary_a = cross_ff[4]; rsp_in.out_bary_b = cross_ff[5];
         rsp_in.out_bary_c = cross_ff[6];
         rsp_in.vertex_valid = 1'b1;
         rsp_in.polygon_end = fin_ff && (close_ff || close_empty) && in_a && out_b;
      end else if (state_ff == ST_EMIT_B) begin
         rsp_in.out_x = eb[0]; rsp_in.out_y = eb[1];
         rsp_in.out_z = eb[2]; rsp_in.out_w = eb[3];
         rsp_in.out_bary_a = eb[4]; rsp_in.out_bary_b = eb[5];
         rsp_in.out_bary_c = eb[6];
         rsp_in.vertex_valid = 1'b1;
         rsp_in.polygon_end = fin_ff && (close_ff || close_empty);
      end else if (state_ff == ST_MARK) begin
         rsp_in.polygon_end = 1'b1;
      end
   end

   // The last emitted word of the closing edge carries polygon_end. When the
   // closing edge is empty, the mark goes on the last word of the open edge.
   assign rsp_data = rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         plane_ff <= CoordBits'(65536);
         keep_ff <= 1'b1;
         start_ff <= 1'b1;
         close_ff <= 1'b0;
         emitted_ff <= 1'b0;
         fin_ff <= 1'b0;
         cnt_ff <= '0;
         comp_ff <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         close_ff <= close_in;
         emitted_ff <= emitted_in;
         fin_ff <= fin_in;
         cnt_ff <= cnt_in;
         comp_ff <= comp_in;
         if (csr_write && csr_index == CSR_PLANE) plane_ff <= csr_wdata;
         if (csr_write && csr_index == CSR_KEEP) keep_ff <= csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      t_ff <= t_in;
      if (save_cross) cross_ff[comp_ff] <= blended;
      if (load_cur) begin
         cur_ff[0] <= req_data.pos_x;  cur_ff[1] <= req_data.pos_y;
         cur_ff[2] <= req_data.pos_z;  cur_ff[3] <= req_data.pos_w;
         cur_ff[4] <= req_data.bary_a; cur_ff[5] <= req_data.bary_b;
         cur_ff[6] <= req_data.bary_c;
         if (state_ff == ST_IDLE) begin
            prev_ff <= cur_ff;
            if (start_ff) begin
               first_ff[0] <= req_data.pos_x;  first_ff[1] <= req_data.pos_y;
               first_ff[2] <= req_data.pos_z;  first_ff[3] <= req_data.pos_w;
               first_ff[4] <= req_data.bary_a; first_ff[5] <= req_data.bary_b;
               first_ff[6] <= req_data.bary_c;
            end
         end
      end
   end

   `PDPC_ASSERT_IMP(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_ready)
   `PDPC_ASSERT_IMP(a_mark_bare, clock, reset,
      rsp_valid && !rsp_data.vertex_valid, rsp_data.polygon_end)
   `PDPC_ASSERT_NEXT(a_div_to_blend, clock, reset,
      state_ff == ST_DIV && cnt_ff == CntBits'(FracBits - 1), state_ff == ST_BLEND)
endmodule

### sim/tb.sv
// Testbench for the depth-plane polygon clipper: scoreboard, stimulus and checks
`timescale 1ns / 1ps
module tb;
   import pdpc_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CsrIdxBits-1:0]  csr_index = '0;
   logic [CsrDataBits-1:0] csr_wdata = '0;

   int  error_count = 0;
   bit  hold_rsp = 1'b0;
   bit  stim_done = 1'b0;

   polygon_depth_plane_clipper uut (.*);

   always #2 clock = ~clock;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   typedef logic signed [63:0] wide_type;
   typedef wide_type vertex_type [NumComp];

   class clip_scoreboard;
      logic signed [CoordBits-1:0] plane = 32'sd65536;
      bit                          keep_hi = 1'b1;
      vertex_type                  first_v, prev_v;
      bit                          at_start = 1'b1;
      rsp_type                     pending[$];

      function new();
         foreach (first_v[j]) begin
            first_v[j] = 0;
            prev_v[j] = 0;
         end
      endfunction

      function void set_reg(input logic [CsrIdxBits-1:0] idx, input logic [31:0] v);
         if (idx == CSR_PLANE) plane = v;
         else if (idx == CSR_KEEP) keep_hi = v[0];
      endfunction

      function void push_vertex(input vertex_type v);
         rsp_type r;
         r = '0;
         r.out_x = v[0]; r.out_y = v[1]; r.out_z = v[2]; r.out_w = v[3];
         r.out_bary_a = v[4]; r.out_bary_b = v[5]; r.out_bary_c = v[6];
         r.vertex_valid = 1'b1;
         pending.push_back(r);
      endfunction

      function wide_type lerp(input wide_type a, input wide_type b, input logic [63:0] t);
         wide_type d;
         logic [63:0] mag, p;
         d = b - a;
         mag = (d < 0) ? -d : d;
         p = (mag >> FracBits) * t + (((mag & 64'hFFFF) * t + 64'h8000) >> FracBits);
         return (d < 0) ? a - wide_type'(p) : a + wide_type'(p);
      endfunction

      // restoring divide: floor(num * 2^FracBits / den)
      function logic [63:0] ratio(input logic [63:0] num, input logic [63:0] den);
         logic [63:0] q, rem;
         if (den == 0) return 0;
         q = (num >= den) ? 1 : 0;
         rem = q ? num - den : num;
         for (int i = 0; i < FracBits; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
               rem -= den;
               q[0] = 1'b1;
            end
         end
         return q;
      endfunction

      function int clip_edge(input vertex_type a, input vertex_type b);
         wide_type z, da, db;
         bit in_a, out_a, in_b, out_b;
         logic [63:0] t;
         vertex_type c;
         z = plane;
         in_a = keep_hi ? a[3] > z : a[3] < z;
         out_a = keep_hi ? a[3] < z : a[3] > z;
         in_b = keep_hi ? b[3] > z : b[3] < z;
         out_b = keep_hi ? b[3] < z : b[3] > z;
         if (out_a && out_b) return 0;
         if (in_a && in_b) begin
            push_vertex(b);
            return 1;
         end
         da = a[3] - z;
         db = b[3] - z;
         t = ratio((da < 0) ? -da : da, ((da < 0) ? -da : da) + ((db < 0) ? -db : db));
         foreach (c[j]) c[j] = lerp(a[j], b[j], t);
         push_vertex(c);
         if (in_a && out_b) return 1;
         push_vertex(b);
         return 2;
      endfunction

      function void note_input(input req_type w);
         vertex_type cur;
         int n;
         rsp_type r;
         n = 0;
         cur[0] = w.pos_x; cur[1] = w.pos_y; cur[2] = w.pos_z; cur[3] = w.pos_w;
         cur[4] = w.bary_a; cur[5] = w.bary_b; cur[6] = w.bary_c;
         if (at_start) begin
            first_v = cur;
            at_start = 1'b0;
         end else begin
            n += clip_edge(prev_v, cur);
         end
         prev_v = cur;
         if (w.final_vertex) begin
            n += clip_edge(cur, first_v);
            if (n == 0) begin
               r = '0;
               pending.push_back(r);
            end
            r = pending.pop_back();
            r.polygon_end = 1'b1;
            pending.push_back(r);
            at_start = 1'b1;
         end
      endfunction

      task check_result(input rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word %h", got));
            return;
         end
         e = pending.pop_front();
         if (got.out_x !== e.out_x) report($sformatf("x %h exp %h", got.out_x, e.out_x));
         if (got.out_y !== e.out_y) report($sformatf("y %h exp %h", got.out_y, e.out_y));
         if (got.out_z !== e.out_z) report($sformatf("z %h exp %h", got.out_z, e.out_z));
         if (got.out_w !== e.out_w) report($sformatf("w %h exp %h", got.out_w, e.out_w));
         if (got.out_bary_a !== e.out_bary_a)
            report($sformatf("bary_a %h exp %h", got.out_bary_a, e.out_bary_a));
         if (got.out_bary_b !== e.out_bary_b)
            report($sformatf("bary_b %h exp %h", got.out_bary_b, e.out_bary_b));
         if (got.out_bary_c !== e.out_bary_c)
            report($sformatf("bary_c %h exp %h", got.out_bary_c, e.out_bary_c));
         if (got.vertex_valid !== e.vertex_valid) report("vertex_valid");
         if (got.polygon_end !== e.polygon_end) report("polygon_end");
      endtask
   endclass

   clip_scoreboard clip_sb = new();

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) clip_sb.check_result(rsp_data);
   end

   initial begin : rsp_side
      int gap;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // valid stays up into a back-to-back word; it drops only ahead of a gap
   task automatic send_vertex(input req_type w, input bit idle_ok);
      int gap;
      gap = (idle_ok && $urandom_range(0, 2) != 0) ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      clip_sb.note_input(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (clip_sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxBits-1:0] idx, input logic [31:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      clip_sb.set_reg(idx, v);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         default: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
      endcase
   endfunction

   function automatic req_type rand_vertex(input logic [31:0] plane, input bit fin);
      req_type w;
      w.pos_x = pick_coord(); w.pos_y = pick_coord(); w.pos_z = pick_coord();
      w.bary_a = pick_coord(); w.bary_b = pick_coord(); w.bary_c = pick_coord();
      // w mostly near half the plane value so edges cross; keep the sum in range
      case ($urandom_range(0, 4))
         0: w.pos_w = plane;
         1: w.pos_w = $urandom;
         default: w.pos_w = $signed(plane) / 2 + ($signed($urandom_range(0, 32'h0004_0000))
                           - 32'sh0002_0000);
      endcase
      w.final_vertex = fin;
      return w;
   endfunction

   task automatic send_polygon(input int n, input logic [31:0] plane, input bit idle_ok);
      for (int i = 0; i < n; i++) send_vertex(rand_vertex(plane, i == n - 1), idle_ok);
   endtask

   function automatic req_type mk(input logic [31:0] c, input logic [31:0] w, input bit f);
      req_type v;
      v = '{c, ~c, c ^ 32'h5A5A_5A5A, w, c, -c, 32'h0001_0000, f};
      return v;
   endfunction

   initial begin : stimulus
      logic [31:0] planes [5];
      int sent;
      planes = '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: single vertex, all-out bare marker, on-plane, crossings
      send_vertex(mk(32'h0001_2345, 32'h0002_0000, 1'b1), 0);
      send_vertex(mk(32'h0000_0001, 32'h0000_0000, 1'b1), 0);
      send_vertex(mk(32'h0, 32'h0001_0000, 1'b0), 0);
      send_vertex(mk(32'h7FFF_FFFF, 32'h0001_0000, 1'b1), 0);
      send_vertex(mk(32'h8000_0000, 32'h0003_0000, 1'b0), 0);
      send_vertex(mk(32'h7FFF_FFFF, 32'hFFFF_0000, 1'b0), 0);
      send_vertex(mk(32'hFFFF_FFFF, 32'h0000_8000, 1'b1), 0);
      drain();
      write_reg(CSR_KEEP, 32'h0);
      write_reg(CSR_PLANE, 32'h0000_8000);
      // far mode leaving edge and entering edge
      send_vertex(mk(32'h0001_0000, 32'h0000_0000, 1'b0), 0);
      send_vertex(mk(32'hFFF0_0000, 32'h0001_0000, 1'b0), 0);
      send_vertex(mk(32'h0100_0000, 32'hFFFF_0000, 1'b1), 0);
      send_vertex(mk(32'h0000_1111, 32'h8000_0000, 1'b0), 0);
      send_vertex(mk(32'h0000_2222, 32'h7FFF_FFFF, 1'b1), 0);
      drain();
      sent = 12;
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_PLANE, planes[ph % 5]);
         write_reg(CSR_KEEP, ph[0]);
         if (ph == 3) begin
            // receiver holds off while vertices keep coming
            hold_rsp = 1'b1;
            send_polygon(6, planes[ph % 5], 0);
            sent += 6;
         end
         while (sent < 42 * (ph + 1)) begin
            int n;
            n = $urandom_range(1, 6);
            send_polygon(n, planes[ph % 5], ph != 5);
            sent += n;
            if ($urandom_range(0, 9) == 0) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (clip_sb.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
      stim_done = 1'b1;
   end

   initial begin : finish_ctl
      wait (stim_done);
      if (error_count == 0)
         $display("PASS polygon_depth_plane_clipper");
      else
         $display("FAIL polygon_depth_plane_clipper");
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("FAIL polygon_depth_plane_clipper");
      $finish;
   end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/pdpc_pkg.sv
rtl/core/polygon_depth_plane_clipper.sv
sim/tb.sv
